// ===== sv/cfpv_pkg.sv =====
package cfpv_pkg;

    localparam int unsigned DEF_MAX_FRAME_BYTES = 256;
    localparam int unsigned FRAME_BYTES_W       = 9;
    localparam int unsigned CFG_INDEX_W         = 2;
    localparam int unsigned CFG_DATA_W          = 8;

    localparam logic [7:0]  HEADER_FIRST_RST  = 8'hA5;
    localparam logic [7:0]  HEADER_SECOND_RST = 8'h5A;
    localparam logic        CRC_ENABLE_RST    = 1'b1;
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;
    localparam logic [9:0]  LEN_OVERHEAD      = 10'd5;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_FIRST  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_SECOND = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CRC_ENABLE    = 2'd2;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_HEADER   = 3'd1,
        ST_LENGTH   = 3'd2,
        ST_CRC      = 3'd3,
        ST_OVERLONG = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } cfpv_in_t;

    typedef struct packed {
        status_t                  status;
        logic [7:0]               command;
        logic [15:0]              var_address;
        logic [15:0]              var_value;
        logic [FRAME_BYTES_W-1:0] frame_bytes;
    } cfpv_out_t;

    typedef struct packed {
        logic [7:0] header_first;
        logic [7:0] header_second;
        logic       crc_enable;
    } cfpv_cfg_t;

    // Reflected CRC-16 update over one byte, LSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== sv/cfpv_frame.sv =====
module cfpv_frame #(
    parameter int unsigned MAX_FRAME_BYTES = cfpv_pkg::DEF_MAX_FRAME_BYTES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cfpv_pkg::cfpv_cfg_t cfg,
    input  logic                accept,
    input  cfpv_pkg::cfpv_in_t  item,
    output logic                result_valid,
    output cfpv_pkg::cfpv_out_t result
);
    import cfpv_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 2);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_FRAME_BYTES);
    localparam logic [CNT_W-1:0] CNT_SAT  = CNT_W'(MAX_FRAME_BYTES + 1);
    localparam logic [CNT_W-1:0] POS_HDR0 = CNT_W'(0);
    localparam logic [CNT_W-1:0] POS_HDR1 = CNT_W'(1);
    localparam logic [CNT_W-1:0] POS_LEN  = CNT_W'(2);
    localparam logic [CNT_W-1:0] POS_CMD  = CNT_W'(3);
    localparam logic [CNT_W-1:0] POS_ADR0 = CNT_W'(4);
    localparam logic [CNT_W-1:0] POS_ADR1 = CNT_W'(5);

    logic [CNT_W-1:0] count_reg,   count_next;
    logic             hdr_good_reg, hdr_good_next;
    logic [7:0]       length_reg,  length_next;
    logic [7:0]       command_reg, command_next;
    logic [15:0]      address_reg, address_next;
    logic [15:0]      crc_reg,     crc_next;
    logic [31:0]      tail_reg,    tail_next;

    logic [CNT_W-1:0] count_new;
    logic             hdr_good_new;
    logic [7:0]       length_new;
    logic [7:0]       command_new;
    logic [15:0]      address_new;
    logic [15:0]      crc_new;
    logic [31:0]      tail_new;
    logic [15:0]      rx_crc;
    logic [CNT_W-1:0] nbytes_sat;
    logic [7:0]       b;

    assign b = item.rx_byte;

    // Fold the current byte into the frame state
    always_comb
    begin
        hdr_good_new = hdr_good_reg;
        if ((count_reg == POS_HDR0 && b != cfg.header_first) ||
            (count_reg == POS_HDR1 && b != cfg.header_second))
            hdr_good_new = 1'b0;

        length_new  = (count_reg == POS_LEN) ? b : length_reg;
        command_new = (count_reg == POS_CMD) ? b : command_reg;
        address_new = address_reg;
        if (count_reg == POS_ADR0)
            address_new = {b, 8'h00};
        else if (count_reg == POS_ADR1)
            address_new = {address_reg[15:8], b};

        // hash the byte two back, keeping the CRC bytes out of the sum
        crc_new   = (count_reg >= POS_ADR1) ? crc16_byte(crc_reg, tail_reg[15:8]) : crc_reg;
        tail_new  = {tail_reg[23:0], b};
        count_new = (count_reg < CNT_SAT) ? count_reg + CNT_W'(1) : count_reg;
    end

    assign rx_crc     = {tail_new[7:0], tail_new[15:8]};
    assign nbytes_sat = (count_new > CNT_MAX) ? CNT_MAX : count_new;

    always_comb
    begin
        if (count_new > CNT_MAX)
            result.status = ST_OVERLONG;
        else if (!hdr_good_new || count_new < CNT_W'(2))
            result.status = ST_HEADER;
        else if ({2'b00, length_new} + LEN_OVERHEAD != 10'(count_new))
            result.status = ST_LENGTH;
        else if (cfg.crc_enable && rx_crc != crc_new)
            result.status = ST_CRC;
        else
            result.status = ST_OK;
        result.command     = command_new;
        result.var_address = address_new;
        result.var_value   = tail_new[31:16];
        result.frame_bytes = FRAME_BYTES_W'(nbytes_sat);
    end

    assign result_valid = accept & item.frame_end;

    always_comb
    begin
        count_next    = count_reg;
        hdr_good_next = hdr_good_reg;
        length_next   = length_reg;
        command_next  = command_reg;
        address_next  = address_reg;
        crc_next      = crc_reg;
        tail_next     = tail_reg;
        if (accept) begin
            if (item.frame_end) begin
                // clear for the next frame
                count_next    = '0;
                hdr_good_next = 1'b1;
                length_next   = '0;
                command_next  = '0;
                address_next  = '0;
                crc_next      = CRC_INIT;
                tail_next     = '0;
            end else begin
                count_next    = count_new;
                hdr_good_next = hdr_good_new;
                length_next   = length_new;
                command_next  = command_new;
                address_next  = address_new;
                crc_next      = crc_new;
                tail_next     = tail_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg    <= '0;
            hdr_good_reg <= 1'b1;
            length_reg   <= '0;
            command_reg  <= '0;
            address_reg  <= '0;
            crc_reg      <= CRC_INIT;
            tail_reg     <= '0;
        end else begin
            count_reg    <= count_next;
            hdr_good_reg <= hdr_good_next;
            length_reg   <= length_next;
            command_reg  <= command_next;
            address_reg  <= address_next;
            crc_reg      <= crc_next;
            tail_reg     <= tail_next;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_SAT)
        else $error("byte count past saturation");
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.frame_end) |=> (count_reg == '0 && crc_reg == CRC_INIT))
        else $error("frame state not cleared after frame end");
    a_hdr_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(hdr_good_reg) |-> ($past(count_reg) == POS_HDR0 || $past(count_reg) == POS_HDR1))
        else $error("header flag dropped outside header bytes");
`endif

endmodule

// ===== sv/cfpv_out_buf.sv =====
module cfpv_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cfpv_pkg::cfpv_out_t push_data,
    output logic                can_push,
    output logic                out_valid,
    input  logic                out_ready,
    output cfpv_pkg::cfpv_out_t out_data
);
    import cfpv_pkg::*;

    logic      main_valid_reg, main_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    cfpv_out_t main_reg, main_next;
    cfpv_out_t skid_reg, skid_next;
    logic      take;

    assign take      = main_valid_reg & out_ready;
    assign can_push  = ~skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (take || !main_valid_reg) begin
            if (skid_valid_reg) begin
                // advance the skid entry, refill skid from the new result
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_next       = push_data;
                skid_valid_next = push;
            end else begin
                main_next       = push_data;
                main_valid_next = push;
            end
        end else if (push) begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

`ifndef ASSERT_OFF
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held with empty output register");
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (push && skid_valid_reg) |-> take)
        else $error("result pushed into a full buffer");
    a_skid_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && take) |=> (main_valid_reg && main_reg == $past(skid_reg)))
        else $error("skid entry not advanced on transfer");
`endif

endmodule

// ===== sv/crc_framed_packet_validator.sv =====
// Output: a frame's result is registered into the output register, or into the
//   skid entry when the output register cannot take it, on the transfer of its last byte.
// Throughput: one byte per cycle unless both output entries are full; the
//   byte-wide CRC-16 update is unrolled in the state logic, and a two-entry
//   output buffer keeps input moving while a result waits.
// Reset (rst_n, async low): config returns to 0xA5 / 0x5A / CRC on, frame state clears.
module crc_framed_packet_validator #(
    parameter int unsigned MAX_FRAME_BYTES = cfpv_pkg::DEF_MAX_FRAME_BYTES
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // byte input
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  cfpv_pkg::cfpv_in_t                     in_data,
    // frame result output
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output cfpv_pkg::cfpv_out_t                    out_data,
    // configuration write port
    input  logic                                   cfg_we,
    input  logic [cfpv_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [cfpv_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import cfpv_pkg::*;

    cfpv_cfg_t cfg_reg, cfg_next;
    logic      accept;
    logic      result_valid;
    cfpv_out_t result;
    logic      can_push;

    // Register decode; writes to an unused index drop silently
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_HEADER_FIRST:  cfg_next.header_first  = cfg_data;
                REG_HEADER_SECOND: cfg_next.header_second = cfg_data;
                REG_CRC_ENABLE:    cfg_next.crc_enable    = cfg_data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.header_first  <= HEADER_FIRST_RST;
            cfg_reg.header_second <= HEADER_SECOND_RST;
            cfg_reg.crc_enable    <= CRC_ENABLE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Hold input only when both output entries are full
    assign in_ready = can_push;
    assign accept   = in_valid & in_ready;

    // Per-frame tracking: header, length, command, address, CRC and tail bytes
    cfpv_frame #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_frame (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .accept       (accept),
        .item         (in_data),
        .result_valid (result_valid),
        .result       (result)
    );

    // Output register plus skid entry
    cfpv_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (result_valid),
        .push_data (result),
        .can_push  (can_push),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

`ifndef ASSERT_OFF
    a_result_from_end: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid)) |-> $past(accept && in_data.frame_end))
        else $error("result appeared without a frame end transfer");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.frame_bytes <= FRAME_BYTES_W'(MAX_FRAME_BYTES)))
        else $error("frame byte count above maximum");
`endif

endmodule
